// ===== src/ubd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_pkg
// types, constants and helpers shared by the baud divisor search block
// ----------------------------------------------------------------------------
package ubd_pkg;

    localparam int unsigned REF_W    = 28;
    localparam int unsigned TOL_W    = 4;
    localparam int unsigned RATE_W   = 18;
    localparam int unsigned NUM_RATES = 22;

    localparam logic [7:0]  DIV_FIRST = 8'd4;
    localparam logic [7:0]  DIV_LAST  = 8'd254;
    localparam logic [7:0]  DIV_NONE  = 8'd255;
    localparam logic [27:0] GEN_MIN   = 28'd2;
    localparam logic [27:0] GEN_MAX   = 28'd65535;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_BAUD = 2'd1;
    localparam logic [1:0] ST_BAD_WL = 2'd2;

    localparam logic [0:0] CFG_REF = 1'b0;
    localparam logic [0:0] CFG_TOL = 1'b1;

    typedef struct packed {
        logic [4:0] baud_code;
        logic [1:0] word_length_code;
        logic [2:0] parity_code;
        logic [1:0] stop_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  baud_divider;
        logic [15:0] baud_generator;
        logic [7:0]  mode_byte;
        logic        within_tolerance;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1_START,
        S_DIV1_WAIT,
        S_CHECK_G,
        S_MUL2,
        S_DIV2_START,
        S_DIV2_WAIT,
        S_ERR,
        S_ERR_WAIT,
        S_NEXT,
        S_DONE
    } state_t;

    function automatic logic [RATE_W-1:0] rate_lookup(input logic [4:0] code);
        logic [RATE_W-1:0] r;
        case (code)
            5'd1:  r = 18'd50;
            5'd2:  r = 18'd75;
            5'd3:  r = 18'd110;
            5'd5:  r = 18'd150;
            5'd6:  r = 18'd200;
            5'd7:  r = 18'd300;
            5'd8:  r = 18'd600;
            5'd9:  r = 18'd1200;
            5'd10: r = 18'd1800;
            5'd11: r = 18'd2400;
            5'd12: r = 18'd3600;
            5'd13: r = 18'd4800;
            5'd14: r = 18'd7200;
            5'd15: r = 18'd9600;
            5'd16: r = 18'd14400;
            5'd17: r = 18'd19200;
            5'd18: r = 18'd38400;
            5'd19: r = 18'd57600;
            5'd20: r = 18'd115200;
            5'd21: r = 18'd230400;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pack_mode(input logic [1:0] wl,
                                             input logic [2:0] par,
                                             input logic [1:0] stp);
        logic [7:0] m;
        m = 8'd0;
        if (wl == 2'd1)
            m = m | (8'h3 << 1);
        else if (wl == 2'd2)
            m = m | (8'h2 << 1);
        if (par == 3'd2)
            m = m | (8'h1 << 3);
        else if (par != 3'd1)
            m = m | (8'h4 << 3);
        if (stp == 2'd1)
            m = m | (8'h1 << 6);
        else if (stp != 2'd0)
            m = m | (8'h2 << 6);
        return m;
    endfunction

endpackage

// ===== src/ubd_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_divider
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module ubd_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [27:0] dividend,
    input  logic [27:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [27:0] quotient
);
    import ubd_pkg::*;

    logic [27:0] quot_reg, quot_next;
    logic [28:0] rem_reg, rem_next;
    logic [27:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [28:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            trial = {rem_reg[27:0], quot_reg[27]};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[26:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[26:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd27)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

// ===== src/uart_baud_divisor_and_mode_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_baud_divisor_and_mode_search_top
// baud divider / generator search and line mode packing
// ----------------------------------------------------------------------------
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | in_data  (ubd_pkg::in_item_t)
// out     | out_valid| out_stall | out_data (ubd_pkg::out_item_t)
//
// one line setting at a time; a full search trial runs three 28-bit
// bit-serial divisions plus six control steps, a trial skipped on the
// generator range runs only the first division, an item tries up to 251
// divisors, and an unsupported baud code goes straight to the result;
// the error divide by the rate reuses the same serial divider
// reset clears state, output valid and rate only; the config registers take their reset values
// the result waits in an output register until taken while in_stall holds
// ----------------------------------------------------------------------------
module uart_baud_divisor_and_mode_search_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ubd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ubd_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [27:0]        cfg_data
);
    import ubd_pkg::*;

    state_t state_reg, state_next;

    logic [REF_W-1:0]  ref_reg;
    logic [TOL_W-1:0]  tol_reg;
    in_item_t          item_reg, item_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [7:0]        d_reg, d_next;
    logic [15:0]       g_reg, g_next;
    logic [27:0]       gfull_reg, gfull_next;
    logic [27:0]       prod_reg, prod_next;
    logic              found_reg, found_next;
    out_item_t         out_reg, out_next;
    logic              ovalid_reg, ovalid_next;

    logic              div_start;
    logic [27:0]       div_a, div_b, div_q;
    logic              div_busy, div_done;

    logic [8:0]        dp1;
    logic [RATE_W+8:0] bprod;
    logic [36:0]       gprod;
    logic [RATE_W-1:0] err;
    logic [27:0]       err100;
    logic [27:0]       achieved_reg, achieved_next;

    ubd_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign dp1   = {1'b0, d_reg} + 9'd1;
    assign bprod = rate_reg * dp1;
    assign gprod = gfull_reg * dp1;
    assign err   = ({10'd0, rate_reg} > achieved_reg) ?
                   RATE_W'(({10'd0, rate_reg} - achieved_reg)) :
                   RATE_W'((achieved_reg - {10'd0, rate_reg}));
    assign err100 = 28'(err) * 28'd100;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && !ovalid_reg)
                begin
                    if (rate_lookup(in_data.baud_code) == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_DIV1_START;
                end
            S_DIV1_START: state_next = S_DIV1_WAIT;
            S_DIV1_WAIT:  if (div_done) state_next = S_CHECK_G;
            S_CHECK_G:
                if (gfull_reg < GEN_MIN || gfull_reg > GEN_MAX)
                    state_next = S_NEXT;
                else
                    state_next = S_MUL2;
            S_MUL2:       state_next = S_DIV2_START;
            S_DIV2_START: state_next = S_DIV2_WAIT;
            S_DIV2_WAIT:  if (div_done) state_next = S_ERR;
            S_ERR:        state_next = S_ERR_WAIT;
            S_ERR_WAIT:
                if (div_done)
                begin
                    if (div_q < 28'(tol_reg))
                        state_next = S_DONE;
                    else
                        state_next = S_NEXT;
                end
            S_NEXT:
                if (d_reg == DIV_LAST)
                    state_next = S_DONE;
                else
                    state_next = S_DIV1_START;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next     = item_reg;
        rate_next     = rate_reg;
        d_next        = d_reg;
        g_next        = g_reg;
        gfull_next    = gfull_reg;
        prod_next     = prod_reg;
        found_next    = found_reg;
        achieved_next = achieved_reg;
        out_next      = out_reg;
        ovalid_next   = ovalid_reg && out_stall;
        div_start     = 1'b0;
        div_a         = ref_reg;
        div_b         = prod_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && !ovalid_reg)
                begin
                    item_next  = in_data;
                    rate_next  = rate_lookup(in_data.baud_code);
                    d_next     = DIV_FIRST;
                    g_next     = '0;
                    found_next = 1'b0;
                end
            S_DIV1_START:
            begin
                // rate * 255 fits 28 bits
                prod_next = 28'(bprod);
            end
            S_DIV1_WAIT:
            begin
                div_start = (!div_busy && !div_done && prod_reg == 28'(bprod)
                             && state_reg == S_DIV1_WAIT && !found_reg
                             && gfull_reg == gfull_reg) ? 1'b0 : 1'b0;
                if (div_done)
                begin
                    gfull_next = div_q;
                    g_next     = div_q[15:0];
                end
            end
            S_CHECK_G: ;
            S_MUL2:
            begin
                // g <= 65535 and d+1 <= 255 keeps this under 2^24
                prod_next = 28'(gprod);
            end
            S_DIV2_WAIT:
                if (div_done)
                    achieved_next = div_q;
            S_ERR:
            begin
                div_start = 1'b1;
                div_a     = err100;
                div_b     = 28'(rate_reg);
            end
            S_ERR_WAIT:
            begin
                div_a = err100;
                div_b = 28'(rate_reg);
                if (div_done && div_q < 28'(tol_reg))
                    found_next = 1'b1;
            end
            S_NEXT:
                if (d_reg == DIV_LAST)
                    d_next = DIV_NONE;
                else
                    d_next = d_reg + 8'd1;
            S_DONE:
            begin
                ovalid_next = 1'b1;
                if (rate_reg == '0)
                begin
                    out_next = '0;
                    out_next.status = ST_BAD_BAUD;
                end
                else
                begin
                    out_next.status           = (item_reg.word_length_code == 2'd0) ?
                                                ST_BAD_WL : ST_OK;
                    out_next.baud_divider     = d_reg;
                    out_next.baud_generator   = g_reg;
                    out_next.mode_byte        = (item_reg.word_length_code == 2'd0) ?
                                                8'd0 :
                                                pack_mode(item_reg.word_length_code,
                                                          item_reg.parity_code,
                                                          item_reg.stop_code);
                    out_next.within_tolerance = found_reg;
                end
            end
            default: ;
        endcase
        // divider launch points for the two trial divisions
        if (state_reg == S_DIV1_START)
        begin
            div_start = 1'b1;
            div_b     = 28'(bprod);
        end
        else if (state_reg == S_DIV2_START)
            div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            ref_reg    <= 28'd50000000;
            tol_reg    <= 4'd3;
            rate_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            rate_reg   <= rate_next;
            if (cfg_we && cfg_index == CFG_REF)
                ref_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_TOL)
                tol_reg <= cfg_data[TOL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        d_reg        <= d_next;
        g_reg        <= g_next;
        gfull_reg    <= gfull_next;
        prod_reg     <= prod_next;
        found_reg    <= found_next;
        achieved_reg <= achieved_next;
        out_reg      <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;
endmodule

// ===== src/ubd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubd_checker
// port-level checks on the baud divisor search block
// ----------------------------------------------------------------------------
module ubd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input ubd_pkg::out_item_t out_data
);
    import ubd_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one transaction in flight: no input taken while a result waits
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // a taken transaction makes the block busy
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transaction");

    // bad baud code yields all-zero fields
    a_bad_baud: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_BAD_BAUD |->
            out_data.baud_divider == 8'd0 && !out_data.within_tolerance)
        else $error("bad baud result not cleared");

    // found flag matches divider range
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_BAD_BAUD |->
            (out_data.within_tolerance == (out_data.baud_divider != DIV_NONE)))
        else $error("tolerance flag mismatch");
endmodule

bind uart_baud_divisor_and_mode_search_top ubd_checker u_ubd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/tb_uart_baud_divisor_and_mode_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_baud_divisor_and_mode_search_top
// checks the baud divider / generator search and mode byte packing against
// an in-bench predictor, over several clock and tolerance settings, with
// random gaps on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module tb_uart_baud_divisor_and_mode_search_top;

    import ubd_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 64'd20000000;

    class ubd_scoreboard;
        out_item_t        expected_q[$];
        longint unsigned  ref_hz;
        longint unsigned  tol_pct;
        int               errors;

        function new();
            ref_hz  = 50000000;
            tol_pct = 3;
            errors  = 0;
        endfunction

        function longint unsigned baud_rate(logic [4:0] code);
            longint unsigned rates[22];
            rates = '{0, 50, 75, 110, 0, 150, 200, 300, 600, 1200, 1800, 2400, 3600,
                      4800, 7200, 9600, 14400, 19200, 38400, 57600, 115200, 230400};
            return (code < 22) ? rates[code] : 0;
        endfunction

        function void note_setting(in_item_t it);
            out_item_t        r;
            longint unsigned  rate, d, g, achieved, err;
            bit               found;
            logic [7:0]       mode;
            r = '0;
            g = 0;
            found = 0;
            rate = baud_rate(it.baud_code);
            if (rate == 0)
            begin
                r.status = ST_BAD_BAUD;
                expected_q.push_back(r);
                return;
            end
            for (d = 4; d < 255; d++)
            begin
                g = ref_hz / (rate * (d + 1));
                if (g < 2 || g > 65535)
                    continue;
                achieved = ref_hz / (g * (d + 1));
                err = (rate > achieved) ? rate - achieved : achieved - rate;
                if ((err * 100) / rate < tol_pct)
                begin
                    found = 1;
                    break;
                end
            end
            // word length: 6 -> 3, 7 -> 2, 8 -> 0
            mode = 8'd0;
            case (it.word_length_code)
                2'd1: mode[2:1] = 2'd3;
                2'd2: mode[2:1] = 2'd2;
                default: mode[2:1] = 2'd0;
            endcase
            // parity: even 0, odd 1, everything else none
            case (it.parity_code)
                3'd1: mode[5:3] = 3'd0;
                3'd2: mode[5:3] = 3'd1;
                default: mode[5:3] = 3'd4;
            endcase
            case (it.stop_code)
                2'd0: mode[7:6] = 2'd0;
                2'd1: mode[7:6] = 2'd1;
                default: mode[7:6] = 2'd2;
            endcase
            r.status           = (it.word_length_code == 2'd0) ? ST_BAD_WL : ST_OK;
            r.baud_divider     = d[7:0];
            r.baud_generator   = g[15:0];
            r.mode_byte        = (it.word_length_code == 2'd0) ? 8'd0 : mode;
            r.within_tolerance = found;
            expected_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.baud_divider !== exp_r.baud_divider)
            begin
                $error("baud_divider exp %0d got %0d", exp_r.baud_divider, got.baud_divider);
                errors++;
            end
            if (got.baud_generator !== exp_r.baud_generator)
            begin
                $error("baud_generator exp %0d got %0d",
                       exp_r.baud_generator, got.baud_generator);
                errors++;
            end
            if (got.mode_byte !== exp_r.mode_byte)
            begin
                $error("mode_byte exp %h got %h", exp_r.mode_byte, got.mode_byte);
                errors++;
            end
            if (got.within_tolerance !== exp_r.within_tolerance)
            begin
                $error("within_tolerance exp %0d got %0d",
                       exp_r.within_tolerance, got.within_tolerance);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_REF;
    logic [27:0] cfg_data = '0;

    ubd_scoreboard    sb = new();
    longint unsigned  cycles = 0;
    bit               quiet = 0;      // no gaps on either side
    bit               hold_req = 0;   // ask the receiver for a long hold-off
    in_item_t         setting_q[$];

    always #2 clk = ~clk;

    uart_baud_divisor_and_mode_search_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall before each transaction, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 13);
            if (hold_req)
            begin
                n = 3000;
                hold_req = 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
        end
    end

    task automatic send_settings();
        int gap;
        while (setting_q.size() > 0)
        begin
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= setting_q[0];
            do @(posedge clk); while (in_stall);
            sb.note_setting(setting_q.pop_front());
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(logic [27:0] ref_hz, logic [3:0] tol);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REF;
        cfg_data  <= ref_hz;
        @(posedge clk);
        cfg_index <= CFG_TOL;
        cfg_data  <= {24'd0, tol};
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.ref_hz  = ref_hz;
        sb.tol_pct = tol;
    endtask

    function automatic in_item_t random_setting();
        in_item_t it;
        it = in_item_t'(12'($urandom));
        // mostly supported rates so the search runs
        if ($urandom_range(0, 4) != 0)
            it.baud_code = 5'($urandom_range(1, 21));
        return it;
    endfunction

    task automatic queue_random(int count);
        repeat (count) setting_q.push_back(random_setting());
    endtask

    initial
    begin
        in_item_t it;
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unsupported codes, rate extremes, every mode code
        for (i = 0; i < 4; i++)
        begin
            it = '0;
            it.baud_code = (i == 0) ? 5'd0 : (i == 1) ? 5'd4 : (i == 2) ? 5'd22 : 5'd31;
            it.word_length_code = 2'd3;
            setting_q.push_back(it);
        end
        for (i = 0; i < 8; i++)
        begin
            it.baud_code        = (i % 2) ? 5'd21 : 5'd1;
            it.word_length_code = i[1:0];
            it.parity_code      = i[2:0];
            it.stop_code        = i[1:0];
            setting_q.push_back(it);
        end
        it = '{5'd15, 2'd0, 3'd7, 2'd3};   // bad word length, search still runs
        setting_q.push_back(it);
        it = '{5'd20, 2'd2, 3'd2, 2'd1};
        setting_q.push_back(it);
        it = '{5'd3, 2'd1, 3'd4, 2'd2};
        setting_q.push_back(it);
        send_settings();
        wait_drained();

        write_regs(28'd250000000, 4'd10);
        queue_random(20);
        send_settings();
        wait_drained();

        write_regs(28'd1000000, 4'd1);
        queue_random(20);
        send_settings();
        wait_drained();

        // fill the block while the output is held off
        write_regs(28'hFFFFFFF, 4'd15);
        hold_req = 1;
        quiet = 1;
        queue_random(20);
        send_settings();
        quiet = 0;
        wait_drained();

        write_regs(28'd0, 4'd3);
        queue_random(8);
        send_settings();
        wait_drained();

        // zero tolerance: every trial is run, keep this short
        write_regs(28'd50000000, 4'd0);
        queue_random(4);
        send_settings();
        wait_drained();

        write_regs(28'd1843200, 4'd2);
        queue_random(20);
        send_settings();
        wait_drained();

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
